// ----- rtl/core/spic_pkg.sv -----
`timescale 1ns / 1ps

package spic_pkg;

  // Width of the configuration register index.
  localparam int unsigned CFG_INDEX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_QUERY_LENGTH   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LENGTH     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_TASKS = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_LIMIT      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL_LIMIT = 3'd4;

  // Configuration reset values.
  localparam logic [31:0] RST_QUERY_LENGTH   = 32'd1024;
  localparam logic [31:0] RST_KEY_LENGTH     = 32'd1024;
  localparam logic [31:0] RST_EXPECTED_TASKS = 32'd32;
  localparam logic [15:0] RST_ROW_LIMIT      = 16'd32;
  localparam logic [7:0]  RST_INTERVAL_LIMIT = 8'd16;

  // Verdict codes of a result beat.
  typedef enum logic [1:0] {
    VERDICT_PENDING = 2'd0,
    VERDICT_VALID   = 2'd1,
    VERDICT_INVALID = 2'd2
  } verdict_t;

  // Configuration register set.
  typedef struct packed {
    logic [31:0] query_length;
    logic [31:0] key_length;
    logic [31:0] expected_tasks;
    logic [15:0] row_limit;
    logic [7:0]  interval_limit;
  } cfg_t;

  // One input beat: a key interval with its task header.
  typedef struct packed {
    logic [31:0] task_query_start;
    logic [31:0] task_query_rows;
    logic [31:0] task_interval_total;
    logic [31:0] interval_start;
    logic [31:0] interval_stop;
    logic        plan_end;
  } item_t;

  // One result beat.
  typedef struct packed {
    verdict_t verdict;
    logic     error_seen;
  } result_t;

endpackage

// ----- rtl/core/spic_cfg_regs.sv -----
`timescale 1ns / 1ps

module spic_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [spic_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [31:0]                         cfg_wdata,
  output spic_pkg::cfg_t                      cfg
);
  import spic_pkg::*;

  cfg_t cfg_r;

  // Register file; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.query_length   <= RST_QUERY_LENGTH;
      cfg_r.key_length     <= RST_KEY_LENGTH;
      cfg_r.expected_tasks <= RST_EXPECTED_TASKS;
      cfg_r.row_limit      <= RST_ROW_LIMIT;
      cfg_r.interval_limit <= RST_INTERVAL_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUERY_LENGTH:   cfg_r.query_length   <= cfg_wdata;
        CFG_KEY_LENGTH:     cfg_r.key_length     <= cfg_wdata;
        CFG_EXPECTED_TASKS: cfg_r.expected_tasks <= cfg_wdata;
        CFG_ROW_LIMIT:      cfg_r.row_limit      <= cfg_wdata[15:0];
        CFG_INTERVAL_LIMIT: cfg_r.interval_limit <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/core/spic_check_core.sv -----
`timescale 1ns / 1ps

module spic_check_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  spic_pkg::cfg_t    cfg,
  input  spic_pkg::item_t   item,
  output spic_pkg::result_t result
);
  import spic_pkg::*;

  logic [31:0] query_cursor_r, query_cursor_nxt;
  logic [31:0] last_stop_r, last_stop_nxt;
  logic [31:0] intervals_left_r, intervals_left_nxt;
  logic [31:0] tasks_seen_r, tasks_seen_nxt;
  logic        failed_r, failed_nxt;

  logic        first;
  logic [31:0] remaining;
  logic        hdr_bad;
  logic        ivl_bad;
  logic [32:0] cursor_sum;
  logic [32:0] tasks_sum;
  logic [31:0] cursor_upd;
  logic [31:0] tasks_upd;
  logic [31:0] left_open;
  logic [31:0] left_upd;
  logic        failed_upd;
  logic        plan_ok;

  // Per-beat checks and the next plan state.
  always_comb begin
    first     = (intervals_left_r == 32'd0);
    remaining = (cfg.query_length > query_cursor_r) ?
                (cfg.query_length - query_cursor_r) : 32'd0;

    hdr_bad = first && ((item.task_query_start != query_cursor_r) ||
                        (item.task_query_rows == 32'd0) ||
                        (item.task_query_rows > {16'd0, cfg.row_limit}) ||
                        (item.task_query_rows > remaining) ||
                        (item.task_interval_total == 32'd0) ||
                        (item.task_interval_total > {24'd0, cfg.interval_limit}));

    ivl_bad = (item.interval_start >= item.interval_stop) ||
              (item.interval_stop > cfg.key_length) ||
              (!first && (item.interval_start < last_stop_r));

    // Saturating counters for the cursor and the task count.
    cursor_sum = {1'b0, query_cursor_r} + {1'b0, item.task_query_rows};
    tasks_sum  = {1'b0, tasks_seen_r} + 33'd1;
    cursor_upd = !first ? query_cursor_r :
                 (cursor_sum[32] ? 32'hFFFF_FFFF : cursor_sum[31:0]);
    tasks_upd  = !first ? tasks_seen_r :
                 (tasks_sum[32] ? 32'hFFFF_FFFF : tasks_sum[31:0]);

    left_open  = first ? item.task_interval_total : intervals_left_r;
    left_upd   = (left_open != 32'd0) ? (left_open - 32'd1) : 32'd0;
    failed_upd = failed_r | hdr_bad | ivl_bad;

    plan_ok = !failed_upd && (cursor_upd == cfg.query_length) &&
              (tasks_upd == cfg.expected_tasks) && (left_upd == 32'd0);

    if (item.plan_end) begin
      result.verdict     = plan_ok ? VERDICT_VALID : VERDICT_INVALID;
      result.error_seen  = !plan_ok;
      query_cursor_nxt   = 32'd0;
      last_stop_nxt      = 32'd0;
      intervals_left_nxt = 32'd0;
      tasks_seen_nxt     = 32'd0;
      failed_nxt         = 1'b0;
    end else begin
      result.verdict     = VERDICT_PENDING;
      result.error_seen  = failed_upd;
      query_cursor_nxt   = cursor_upd;
      last_stop_nxt      = item.interval_stop;
      intervals_left_nxt = left_upd;
      tasks_seen_nxt     = tasks_upd;
      failed_nxt         = failed_upd;
    end
  end

  // Plan state advances once per beat leaving the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_cursor_r   <= 32'd0;
      last_stop_r      <= 32'd0;
      intervals_left_r <= 32'd0;
      tasks_seen_r     <= 32'd0;
      failed_r         <= 1'b0;
    end else if (advance) begin
      query_cursor_r   <= query_cursor_nxt;
      last_stop_r      <= last_stop_nxt;
      intervals_left_r <= intervals_left_nxt;
      tasks_seen_r     <= tasks_seen_nxt;
      failed_r         <= failed_nxt;
    end
  end

endmodule

// ----- rtl/core/sparse_interval_plan_checker.sv -----
`timescale 1ns / 1ps

// Streamed checker for a block-sparse attention plan. Each input beat is one
// key interval together with its task header; each beat yields exactly one
// result beat, which stays pending until the plan-end beat reports the plan
// valid or invalid and clears the plan state. The block takes one beat per
// cycle while the output side does not stall: a beat is captured in an input
// register, checked there against the plan state, and its result is held in
// an output register. The plan state (cursor, interval count, task count) is
// updated once for each beat that leaves the input register. The user must
// write the configuration registers only while no beat is in flight; the block
// itself does not enforce this.
module sparse_interval_plan_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [spic_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [31:0]                      in_task_query_start,
  input  logic [31:0]                      in_task_query_rows,
  input  logic [31:0]                      in_task_interval_total,
  input  logic [31:0]                      in_interval_start,
  input  logic [31:0]                      in_interval_stop,
  input  logic                             in_plan_end,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_verdict,
  output logic                             out_error_seen
);
  import spic_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    item_valid_r;
  result_t res;
  result_t res_r;
  logic    res_valid_r;
  logic    advance;

  // Configuration registers.
  spic_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // A held beat moves on when the result register is free or draining.
  assign advance  = item_valid_r && (!res_valid_r || out_ready);
  assign in_ready = !item_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r.task_query_start    <= in_task_query_start;
      item_r.task_query_rows     <= in_task_query_rows;
      item_r.task_interval_total <= in_task_interval_total;
      item_r.interval_start      <= in_interval_start;
      item_r.interval_stop       <= in_interval_stop;
      item_r.plan_end            <= in_plan_end;
    end
  end

  // Checks and plan state.
  spic_check_core u_check_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .cfg     (cfg),
    .item    (item_r),
    .result  (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= 1'b1;
    end else if (out_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid      = res_valid_r;
  assign out_verdict    = res_r.verdict;
  assign out_error_seen = res_r.error_seen;

endmodule

// ----- rtl/core/spic_checker.sv -----
`timescale 1ns / 1ps

module spic_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_verdict,
  input logic       out_error_seen
);
  import spic_pkg::*;

  logic sticky_r;

  // Tracks an error reported on a pending beat until the plan closes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sticky_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (out_verdict != VERDICT_PENDING) begin
        sticky_r <= 1'b0;
      end else if (out_error_seen) begin
        sticky_r <= 1'b1;
      end
    end
  end

  // No result beat is shown right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_verdict) &&
                                $stable(out_error_seen))
    else $error("stalled result beat changed");

  // The error flag agrees with a final verdict.
  a_verdict_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict == VERDICT_PENDING) ||
                  (out_verdict == VERDICT_VALID && !out_error_seen) ||
                  (out_verdict == VERDICT_INVALID && out_error_seen))
    else $error("verdict and error flag disagree");

  // Once reported, an error stays reported until the plan ends.
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && sticky_r |-> out_error_seen && (out_verdict != VERDICT_VALID))
    else $error("plan error dropped before plan end");

endmodule

bind sparse_interval_plan_checker spic_checker u_spic_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_verdict    (out_verdict),
  .out_error_seen (out_error_seen)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import spic_pkg::*;

  // Ways a well-formed plan gets broken before it is sent.
  typedef enum int {
    BRK_START,
    BRK_ROWS_ZERO,
    BRK_ROWS_OVER,
    BRK_TOTAL_ZERO,
    BRK_TOTAL_OVER,
    BRK_EMPTY_IV,
    BRK_STOP_PAST_KEYS,
    BRK_BACKWARD,
    BRK_EARLY_END,
    BRK_NO_END
  } plan_break_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [31:0]            cfg_wdata;
  logic                   in_valid;
  logic                   in_ready;
  logic [31:0]            in_task_query_start;
  logic [31:0]            in_task_query_rows;
  logic [31:0]            in_task_interval_total;
  logic [31:0]            in_interval_start;
  logic [31:0]            in_interval_stop;
  logic                   in_plan_end;
  logic                   out_valid;
  logic                   out_ready;
  logic [1:0]             out_verdict;
  logic                   out_error_seen;

  sparse_interval_plan_checker u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_task_query_start    (in_task_query_start),
    .in_task_query_rows     (in_task_query_rows),
    .in_task_interval_total (in_task_interval_total),
    .in_interval_start      (in_interval_start),
    .in_interval_stop       (in_interval_stop),
    .in_plan_end            (in_plan_end),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_verdict            (out_verdict),
    .out_error_seen         (out_error_seen)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the configuration registers and of the plan state.
  cfg_t        cfg_shadow;
  logic [31:0] plan_cursor = '0;
  logic [31:0] plan_last_stop = '0;
  logic [31:0] plan_intervals_left = '0;
  logic [31:0] plan_tasks = '0;
  logic        plan_failed = 1'b0;

  // Verdicts still owed by the block, oldest first.
  result_t expected_verdicts[$];

  // Beats of the plan being built, and the index of each task's first beat.
  item_t       plan_beats[$];
  int unsigned task_heads[$];

  // Idling controls, shared between the test tasks and the channel processes.
  int send_idle_pct = 0;
  int ready_stall_pct = 0;
  int ready_hold_cycles = 0;
  int mismatch_count = 0;

  // Idle percentages of the sender and the receiver for each idling mode.
  int send_idle_tab[4] = '{0, 79, 0, 34};
  int ready_stall_tab[4] = '{0, 0, 79, 34};

  function automatic longint unsigned lesser(longint unsigned a, longint unsigned b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [31:0] add_saturating(logic [31:0] a, logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  // Advance the plan state by one interval beat and return its verdict.
  function automatic result_t judge_interval(item_t b);
    result_t     r;
    logic        opens_task;
    logic        bad;
    logic        plan_ok;
    logic [31:0] rows_left;
    opens_task = 1'b0;
    bad = 1'b0;
    // A beat opens a task when the previous task has no intervals left.
    if (plan_intervals_left == 0) begin
      rows_left = (cfg_shadow.query_length > plan_cursor) ?
                  cfg_shadow.query_length - plan_cursor : '0;
      opens_task = 1'b1;
      if (b.task_query_start != plan_cursor || b.task_query_rows == 0 ||
          b.task_query_rows > cfg_shadow.row_limit || b.task_query_rows > rows_left ||
          b.task_interval_total == 0 ||
          b.task_interval_total > cfg_shadow.interval_limit) begin
        bad = 1'b1;
      end
      plan_cursor = add_saturating(plan_cursor, b.task_query_rows);
      plan_tasks = add_saturating(plan_tasks, 32'd1);
      plan_intervals_left = b.task_interval_total;
    end
    // Interval bounds, and ordering within a task.
    if (b.interval_start >= b.interval_stop || b.interval_stop > cfg_shadow.key_length ||
        (!opens_task && b.interval_start < plan_last_stop)) begin
      bad = 1'b1;
    end
    plan_last_stop = b.interval_stop;
    if (plan_intervals_left != 0) begin
      plan_intervals_left = plan_intervals_left - 1;
    end
    if (bad) begin
      plan_failed = 1'b1;
    end
    // The last beat of a plan yields the verdict and clears the plan state.
    if (b.plan_end) begin
      plan_ok = !plan_failed && plan_cursor == cfg_shadow.query_length &&
                plan_tasks == cfg_shadow.expected_tasks && plan_intervals_left == 0;
      r.verdict = plan_ok ? VERDICT_VALID : VERDICT_INVALID;
      r.error_seen = !plan_ok;
      plan_cursor = '0;
      plan_last_stop = '0;
      plan_intervals_left = '0;
      plan_tasks = '0;
      plan_failed = 1'b0;
    end else begin
      r.verdict = VERDICT_PENDING;
      r.error_seen = plan_failed;
    end
    return r;
  endfunction

  function automatic item_t make_beat(logic [31:0] q_start, logic [31:0] q_rows,
                                      logic [31:0] iv_total, logic [31:0] k_start,
                                      logic [31:0] k_stop, logic last);
    item_t b;
    b.task_query_start = q_start;
    b.task_query_rows = q_rows;
    b.task_interval_total = iv_total;
    b.interval_start = k_start;
    b.interval_stop = k_stop;
    b.plan_end = last;
    return b;
  endfunction

  function automatic cfg_t random_small_cfg();
    cfg_t c;
    c.expected_tasks = $urandom_range(1, 6);
    c.row_limit = 16'($urandom_range(1, 8));
    c.interval_limit = 8'($urandom_range(1, 6));
    if ($urandom_range(4) != 0) begin
      c.query_length = $urandom_range(c.expected_tasks, c.expected_tasks * c.row_limit);
    end else begin
      c.query_length = $urandom_range(1, 60);
    end
    if ($urandom_range(3) != 0) begin
      c.key_length = $urandom_range(1, 48);
    end else begin
      c.key_length = $urandom_range(1, 32'hFFFF_FFFF);
    end
    return c;
  endfunction

  // Offer one beat; starts and returns just after a falling edge, once it is taken.
  task automatic offer_beat(input item_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_task_query_start <= b.task_query_start;
    in_task_query_rows <= b.task_query_rows;
    in_task_interval_total <= b.task_interval_total;
    in_interval_start <= b.interval_start;
    in_interval_stop <= b.interval_stop;
    in_plan_end <= b.plan_end;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    expected_verdicts.push_back(judge_interval(b));
    @(negedge clk);
  endtask

  task automatic send_plan();
    foreach (plan_beats[i]) begin
      offer_beat(plan_beats[i]);
    end
  endtask

  // Stop sending and wait until every verdict owed has come back.
  task automatic wait_for_verdicts();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (expected_verdicts.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  // Write all registers, with junk above the narrow ones and a write to an unused index.
  task automatic apply_config(input cfg_t c);
    logic [31:0] junk;
    junk = $urandom;
    put_reg(CFG_QUERY_LENGTH, c.query_length);
    put_reg(CFG_KEY_LENGTH, c.key_length);
    put_reg(CFG_EXPECTED_TASKS, c.expected_tasks);
    put_reg(CFG_ROW_LIMIT, {junk[31:16], c.row_limit});
    put_reg(CFG_INTERVAL_LIMIT, {junk[31:8], c.interval_limit});
    put_reg(CFG_INDEX_W'($urandom_range((1 << CFG_INDEX_W) - 1, CFG_INTERVAL_LIMIT + 1)),
            $urandom);
    cfg_we <= 1'b0;
    @(negedge clk);
    cfg_shadow = c;
  endtask

  // Build a random plan, well-formed in most cases where the current settings allow it.
  task automatic build_plan(input int unsigned iv_cap);
    int unsigned     n_tasks;
    int unsigned     extra;
    int unsigned     slot;
    int unsigned     add;
    int unsigned     n_iv;
    int unsigned     base;
    int unsigned     rows_of[$];
    longint unsigned k_len;
    longint unsigned pos;
    longint unsigned max_stop;
    longint unsigned start_k;
    longint unsigned stop_k;
    plan_beats.delete();
    task_heads.delete();
    k_len = cfg_shadow.key_length;
    // Split the query rows over the expected tasks when the settings allow it.
    if (cfg_shadow.expected_tasks <= 32 &&
        cfg_shadow.query_length >= cfg_shadow.expected_tasks &&
        longint'(cfg_shadow.query_length) <=
        longint'(cfg_shadow.expected_tasks) * longint'(cfg_shadow.row_limit) &&
        $urandom_range(9) != 0) begin
      n_tasks = cfg_shadow.expected_tasks;
      repeat (n_tasks) rows_of.push_back(1);
      extra = cfg_shadow.query_length - n_tasks;
      while (extra != 0) begin
        slot = $urandom_range(n_tasks - 1);
        if (rows_of[slot] < cfg_shadow.row_limit) begin
          add = $urandom_range(1, lesser(extra, cfg_shadow.row_limit - rows_of[slot]));
          rows_of[slot] += add;
          extra -= add;
        end
      end
    end else begin
      n_tasks = $urandom_range(1, 4);
      repeat (n_tasks) rows_of.push_back($urandom_range(1, lesser(cfg_shadow.row_limit, 64)));
    end
    // Each task lists ordered intervals; its first one may start anywhere.
    base = 0;
    foreach (rows_of[t]) begin
      n_iv = $urandom_range(1, lesser(lesser(cfg_shadow.interval_limit, iv_cap), k_len));
      task_heads.push_back(plan_beats.size());
      pos = $urandom_range(0, k_len - n_iv);
      for (int j = 0; j < n_iv; j++) begin
        max_stop = k_len - (n_iv - 1 - j);
        start_k = pos + $urandom_range(0, lesser(3, max_stop - 1 - pos));
        if ($urandom_range(3) == 0) begin
          stop_k = max_stop;
        end else begin
          stop_k = start_k + 1 + $urandom_range(0, lesser(5, max_stop - start_k - 1));
        end
        plan_beats.push_back(make_beat(base, rows_of[t], n_iv, 32'(start_k), 32'(stop_k),
                                       1'b0));
        pos = stop_k;
      end
      base += rows_of[t];
    end
    plan_beats[plan_beats.size() - 1].plan_end = 1'b1;
  endtask

  // Break one thing in the plan just built.
  task automatic corrupt_plan();
    plan_break_t how;
    int unsigned at;
    int unsigned head;
    how = plan_break_t'($urandom_range(BRK_NO_END));
    at = $urandom_range(plan_beats.size() - 1);
    head = task_heads[$urandom_range(task_heads.size() - 1)];
    case (how)
      BRK_START: plan_beats[head].task_query_start ^= 32'h1 << $urandom_range(31);
      BRK_ROWS_ZERO: plan_beats[head].task_query_rows = '0;
      BRK_ROWS_OVER:
        plan_beats[head].task_query_rows = cfg_shadow.row_limit + $urandom_range(1, 4);
      BRK_TOTAL_ZERO: plan_beats[head].task_interval_total = '0;
      BRK_TOTAL_OVER:
        plan_beats[head].task_interval_total = cfg_shadow.interval_limit + $urandom_range(1, 4);
      BRK_EMPTY_IV:
        plan_beats[at].interval_stop = plan_beats[at].interval_start - $urandom_range(0, 1);
      BRK_STOP_PAST_KEYS: plan_beats[at].interval_stop = cfg_shadow.key_length + 1;
      BRK_BACKWARD: begin
        if (at != 0 && plan_beats[at - 1].interval_stop != 0) begin
          plan_beats[at].interval_start = $urandom_range(0, plan_beats[at - 1].interval_stop - 1);
        end
      end
      BRK_EARLY_END: begin
        plan_beats[at].plan_end = 1'b1;
        plan_beats = plan_beats[0:at];
      end
      BRK_NO_END: plan_beats[plan_beats.size() - 1].plan_end = 1'b0;
      default: ;
    endcase
  endtask

  // One random phase: mostly plans, some broken, some raw noise beats.
  task automatic run_random_phase(input cfg_t c, input int mode, input int beats,
                                  input int unsigned iv_cap, input int hold);
    int sent;
    item_t nb;
    wait_for_verdicts();
    apply_config(c);
    send_idle_pct = send_idle_tab[mode];
    ready_stall_pct = ready_stall_tab[mode];
    ready_hold_cycles = hold;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(99) < 75) begin
        build_plan(iv_cap);
        if ($urandom_range(3) == 0) begin
          corrupt_plan();
        end
      end else begin
        plan_beats.delete();
        repeat ($urandom_range(1, 4)) begin
          nb = {$urandom, $urandom, $urandom, $urandom, $urandom, 1'b0};
          nb.plan_end = ($urandom_range(7) == 0);
          plan_beats.push_back(nb);
        end
      end
      send_plan();
      sent += plan_beats.size();
    end
  endtask

  // Register reset values seen through the pending error flag.
  task automatic test_reset_values();
    plan_beats = '{
      make_beat(0, 32, 16, 0, 10, 1'b0),
      make_beat(0, 0, 0, 10, 1024, 1'b0),
      make_beat(0, 0, 0, 1024, 1025, 1'b1),
      make_beat(0, 33, 1, 0, 1, 1'b0),
      make_beat(0, 1, 1, 0, 1, 1'b1)
    };
    send_plan();
  endtask

  // Every header and interval check, one short plan each, plus counter saturation.
  task automatic test_header_checks();
    wait_for_verdicts();
    apply_config('{32'd4, 32'd16, 32'd1, 16'd8, 8'd2});
    plan_beats = '{
      make_beat(0, 4, 1, 0, 16, 1'b1),
      make_beat(1, 4, 1, 0, 1, 1'b1),
      make_beat(0, 0, 1, 0, 1, 1'b1),
      make_beat(0, 5, 1, 0, 1, 1'b1),
      make_beat(0, 9, 1, 0, 1, 1'b1),
      make_beat(0, 4, 0, 0, 16, 1'b0),
      make_beat(4, 1, 1, 0, 1, 1'b1),
      make_beat(0, 4, 3, 0, 1, 1'b1),
      make_beat(0, 4, 1, 5, 5, 1'b1),
      make_beat(0, 4, 1, 0, 17, 1'b1),
      make_beat(0, 4, 2, 4, 8, 1'b0),
      make_beat(0, 4, 2, 2, 6, 1'b1),
      make_beat(0, 4, 2, 4, 8, 1'b0),
      make_beat(0, 4, 2, 8, 9, 1'b1),
      make_beat(0, 4, 2, 0, 1, 1'b1),
      make_beat(0, 32'hFFFF_FFFF, 1, 0, 1, 1'b0),
      make_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 1, 1'b0),
      make_beat(0, 4, 1, 0, 1, 1'b1),
      make_beat(0, 4, 1, 0, 16, 1'b1)
    };
    send_plan();
  endtask

  // A new task's first interval may start below the previous task's stop.
  task automatic test_task_boundary();
    wait_for_verdicts();
    apply_config('{32'd4, 32'd16, 32'd2, 16'd8, 8'd2});
    plan_beats = '{
      make_beat(0, 2, 1, 8, 12, 1'b0),
      make_beat(2, 2, 1, 0, 4, 1'b1)
    };
    send_plan();
  endtask

  task automatic test_reset_config_plans();
    run_random_phase('{RST_QUERY_LENGTH, RST_KEY_LENGTH, RST_EXPECTED_TASKS,
                       RST_ROW_LIMIT, RST_INTERVAL_LIMIT}, 0, 130, 3, 0);
  endtask

  task automatic test_extreme_configs();
    run_random_phase('{32'd1, 32'd1, 32'd1, 16'd1, 8'd1}, 1, 80, 4, 0);
    run_random_phase('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF},
                     2, 80, 4, 0);
  endtask

  task automatic test_random_configs();
    for (int p = 0; p < 5; p++) begin
      run_random_phase(random_small_cfg(), p % 4, 100, 4, 0);
    end
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    run_random_phase(random_small_cfg(), 0, 40, 3, 80);
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (ready_hold_cycles != 0) begin
      out_ready <= 1'b0;
      ready_hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  // Compare each result beat with the oldest verdict owed.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: result beat with none expected: verdict=%0d error_seen=%0b",
                 $time, out_verdict, out_error_seen);
        mismatch_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_verdict !== want.verdict) begin
          $display("%0t: verdict mismatch: expected %0d actual %0d",
                   $time, want.verdict, out_verdict);
          mismatch_count++;
        end
        if (out_error_seen !== want.error_seen) begin
          $display("%0t: error_seen mismatch: expected %0b actual %0b",
                   $time, want.error_seen, out_error_seen);
          mismatch_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_task_query_start = '0;
    in_task_query_rows = '0;
    in_task_interval_total = '0;
    in_interval_start = '0;
    in_interval_stop = '0;
    in_plan_end = 1'b0;
    out_ready = 1'b0;
    cfg_shadow = '{RST_QUERY_LENGTH, RST_KEY_LENGTH, RST_EXPECTED_TASKS,
                   RST_ROW_LIMIT, RST_INTERVAL_LIMIT};
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_values();
    test_header_checks();
    test_task_boundary();
    test_reset_config_plans();
    test_extreme_configs();
    test_random_configs();
    test_backpressure();
    wait_for_verdicts();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASS sparse_interval_plan_checker");
    end else begin
      $display("FAIL sparse_interval_plan_checker");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("FAIL sparse_interval_plan_checker");
    $finish;
  end

endmodule
